/* sv/rit_pkg.sv */
// ----------------------------------------------------------------------------
// rit_pkg: shared types and constants of the report interval tracker
// Status codes, clamp limits, register indexes and the stage word passed
// from the estimator to the reload stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rit_pkg;

    localparam int EST_W    = 32;
    localparam int CLAMP_W  = 14;
    localparam int CLK_W    = 8;
    localparam int CNT_W    = 3;
    localparam int SHIFT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int RELOAD_W = 22;
    localparam int CFG_IDX_W = 2;

    localparam logic [STATUS_W-1:0] ST_FIRST   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPOUT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BURST   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 2'd3;

    localparam logic [CLAMP_W-1:0] LDVAL_US_MIN = 14'd125;
    localparam logic [CLAMP_W-1:0] LDVAL_US_MAX = 14'd10000;
    localparam logic [CNT_W-1:0]   COUNT_MAX    = 3'd7;

    // Estimator result on its way to the reload stage
    typedef struct packed {
        logic                  confident;
        logic [STATUS_W-1:0]   status;
        logic [EST_W-1:0]      estimate;
        logic [CLAMP_W-1:0]    est_clamped;
    } t_stage;

    function automatic logic [CLAMP_W-1:0] clamp_us(input logic [EST_W-1:0] v);
        logic [CLAMP_W-1:0] r;
        if (v < EST_W'(LDVAL_US_MIN)) begin
            r = LDVAL_US_MIN;
        end else if (v > EST_W'(LDVAL_US_MAX)) begin
            r = LDVAL_US_MAX;
        end else begin
            r = v[CLAMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/rit_reload.sv */
// ----------------------------------------------------------------------------
// rit_reload: timer reload stage and output register
// Multiplies the clamped estimate by the timer clock, less one (zero for an
// unconfident word), and holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_reload (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire rit_pkg::t_stage           i_stage,
    input  wire logic [rit_pkg::CLK_W-1:0] i_clock_mhz,
    output logic                           o_ready,
    output logic                           o_tvalid,
    input  wire logic                      i_tready,
    // tdata: interval_estimate_us[31:0], timer_reload[53:32], zero pad[55:54]
    output logic [55:0]                    o_tdata,
    // tuser: arrival_status[1:0]
    output logic [rit_pkg::STATUS_W-1:0]   o_tuser
);
    import rit_pkg::*;

    logic                  r_valid;
    logic [EST_W-1:0]      r_est;
    logic [STATUS_W-1:0]   r_status;
    logic [RELOAD_W-1:0]   r_reload;
    logic [RELOAD_W-1:0]   n_reload;
    logic [RELOAD_W-1:0]   prod;
    logic                  take;

    assign o_ready = !r_valid || i_tready;
    assign take    = i_valid && o_ready;

    always_comb begin
        prod = RELOAD_W'(i_stage.est_clamped) * RELOAD_W'(i_clock_mhz);
        if (i_stage.confident && (prod != '0)) begin
            n_reload = prod - RELOAD_W'(1);
        end else begin
            n_reload = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_est    <= i_stage.estimate;
            r_status <= i_stage.status;
            r_reload <= n_reload;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {2'b00, r_reload, r_est};
    assign o_tuser  = r_status;

    // an unconfident word always carries a zero reload
    a_unconf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_stage.confident |=> o_tdata[53:32] == '0)
        else $error("reload given before confidence");

    // reload never exceeds clamp limit times clock
    a_reload_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_reload <= RELOAD_W'(LDVAL_US_MAX) * RELOAD_W'($past(i_clock_mhz)))
        else $error("reload out of range");

endmodule

`default_nettype wire

/* sv/report_interval_tracker.sv */
// ----------------------------------------------------------------------------
// report_interval_tracker: report interval estimator with outlier rejection
// Smooths the gap between report timestamps, rejects dropouts and bursts,
// and derives a periodic timer reload value.
// ----------------------------------------------------------------------------
//  channel   direction  width  content
//  s_axis    in         32     arrival_time_us
//  m_axis    out        56+2   estimate, timer_reload (tdata); status (tuser)
//  cfg       in         2+14   register index, write data
//
//  One word per cycle sustained while the output is not stalled.
//  The estimate and timestamp update complete in the cycle a word is taken,
//  the reload multiply sits in the second stage before the output register.
//  Reset is synchronous and loads the register defaults and a 1000 us estimate.
//  A stalled output holds its word; the input keeps flowing into the stage
//  register until that register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module report_interval_tracker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: arrival_time_us[31:0]
    input  wire logic [31:0]                   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: interval_estimate_us[31:0], timer_reload[53:32], zero pad[55:54]
    output logic [55:0]                        m_axis_tdata,
    // tuser: arrival_status[1:0]
    output logic [rit_pkg::STATUS_W-1:0]       m_axis_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [rit_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [13:0]                   i_cfg_wdata
);
    import rit_pkg::*;

    logic [CLK_W-1:0]    r_clock_mhz;
    logic [CNT_W-1:0]    r_min_reports;
    logic [SHIFT_W-1:0]  r_shift;

    logic [EST_W-1:0]    r_prev;
    logic [EST_W-1:0]    r_est;
    logic [CNT_W-1:0]    r_count;

    logic [EST_W-1:0]    n_est;
    logic [CNT_W-1:0]    n_count;
    logic [STATUS_W-1:0] n_status;

    logic                r_s1_valid;
    t_stage              r_s1;
    t_stage              n_s1;

    logic                s_fire;
    logic                rl_ready;
    logic [EST_W-1:0]    dt;
    logic                cur_nz;
    logic                is_drop;
    logic                is_burst;
    logic [EST_W:0]      diff;
    logic [EST_W:0]      step;
    logic [EST_W-1:0]    ewma;

    assign s_axis_tready = !r_s1_valid || rl_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        dt       = s_axis_tdata - r_prev;
        cur_nz   = (r_est != '0);
        is_drop  = cur_nz && ({2'b00, dt} > {r_est, 2'b00});
        is_burst = cur_nz && (dt < {1'b0, r_est[EST_W-1:1]});
        // signed gap error, floor shift, then step toward the gap
        diff     = {1'b0, dt} - {1'b0, r_est};
        step     = $signed(diff) >>> r_shift;
        ewma     = r_est + step[EST_W-1:0];

        n_est    = r_est;
        n_count  = r_count;
        n_status = ST_UPDATE;
        if (r_count == '0) begin
            n_count  = CNT_W'(1);
            n_status = ST_FIRST;
        end else if (is_drop) begin
            n_status = ST_DROPOUT;
        end else if (is_burst) begin
            n_status = ST_BURST;
        end else begin
            n_est = cur_nz ? ewma : dt;
            if (r_count < COUNT_MAX) begin
                n_count = r_count + CNT_W'(1);
            end
        end

        n_s1.confident   = (n_count >= r_min_reports) && (n_est != '0);
        n_s1.status      = n_status;
        n_s1.estimate    = n_est;
        n_s1.est_clamped = clamp_us(n_est);
    end

    // configuration and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_mhz   <= CLK_W'(24);
            r_min_reports <= CNT_W'(5);
            r_shift       <= SHIFT_W'(4);
            r_prev        <= '0;
            r_est         <= EST_W'(1000);
            r_count       <= '0;
        end else begin
            if (s_fire) begin
                r_prev  <= s_axis_tdata;
                r_est   <= n_est;
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_NOMINAL: r_est <= EST_W'(clamp_us(EST_W'(i_cfg_wdata)));
                    CFG_CLOCK:   r_clock_mhz   <= i_cfg_wdata[CLK_W-1:0];
                    CFG_MIN_REP: r_min_reports <= i_cfg_wdata[CNT_W-1:0];
                    CFG_SHIFT:   r_shift       <= i_cfg_wdata[SHIFT_W-1:0];
                    default:     r_shift       <= r_shift;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_fire) begin
            r_s1_valid <= 1'b1;
        end else if (rl_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1 <= n_s1;
        end
    end

    rit_reload u_reload (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_stage     (r_s1),
        .i_clock_mhz (r_clock_mhz),
        .o_ready     (rl_ready),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser)
    );

    // count is never zero once a word has been taken
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_count != '0)
        else $error("count zero after accept");

    // rejected arrivals leave the estimate alone
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && !i_cfg_we && (n_status == ST_DROPOUT || n_status == ST_BURST)
        |=> r_est == $past(r_est))
        else $error("estimate moved on rejected arrival");

    // an arrival taken while count was zero is flagged first
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && (r_count == '0) |=> r_s1.status == ST_FIRST)
        else $error("first arrival not flagged");

    // a held stage word stays while the reload stage is full
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !rl_ready |=> r_s1_valid && $stable(r_s1))
        else $error("stage word lost under stall");

endmodule

`default_nettype wire

/* sim/report_interval_tracker_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// report_interval_tracker_checker: result scoreboard for the interval tracker
// Watches the input, output and register write ports, keeps its own copy of
// the timestamp, estimate, report count and settings, works out the result
// word for every accepted arrival and compares each delivered word with the
// oldest one still waiting.
// ----------------------------------------------------------------------------

module report_interval_tracker_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    input  wire logic                          i_s_axis_tready,
    input  wire logic [31:0]                   i_s_axis_tdata,
    input  wire logic                          i_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    input  wire logic [55:0]                   i_m_axis_tdata,
    input  wire logic [rit_pkg::STATUS_W-1:0]  i_m_axis_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [rit_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [13:0]                   i_cfg_wdata,
    output int                                 o_pending,
    output int                                 o_errors
);

    import rit_pkg::*;

    typedef struct packed {
        logic [EST_W-1:0]    estimate;
        logic [STATUS_W-1:0] status;
        logic [RELOAD_W-1:0] reload;
    } t_report_word;

    // tracker state and settings as the block should hold them
    logic [31:0]        last_arrival;
    logic [EST_W-1:0]   estimate_us;
    logic [CNT_W-1:0]   report_count;
    logic [CLK_W-1:0]   clk_mhz;
    logic [CNT_W-1:0]   min_count;
    logic [SHIFT_W-1:0] ewma_shift;

    t_report_word expected_reports[$];
    int           mismatch_count = 0;

    function automatic logic [31:0] limit_us(input logic [31:0] v);
        logic [31:0] r;
        if (v < {18'b0, LDVAL_US_MIN}) begin
            r = {18'b0, LDVAL_US_MIN};
        end else if (v > {18'b0, LDVAL_US_MAX}) begin
            r = {18'b0, LDVAL_US_MAX};
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_report_word next_report(input logic [31:0] ts);
        logic [31:0]  gap;
        logic [31:0]  cur;
        logic [32:0]  step;
        logic [31:0]  counts;
        logic [31:0]  counts_m1;
        t_report_word r;
        if (report_count == '0) begin
            last_arrival = ts;
            report_count = 3'd1;
            r.status     = ST_FIRST;
        end else begin
            gap          = ts - last_arrival;
            cur          = estimate_us;
            last_arrival = ts;
            // four times the estimate at full width, so it never wraps
            if (cur != 0 && {2'b00, gap} > {cur, 2'b00}) begin
                r.status = ST_DROPOUT;
            end else if (cur != 0 && gap < (cur >> 1)) begin
                r.status = ST_BURST;
            end else begin
                if (cur == 0) begin
                    estimate_us = gap;
                end else if (gap >= cur) begin
                    estimate_us = cur + ((gap - cur) >> ewma_shift);
                end else begin
                    // round the downward step away from zero (floor of a negative shift)
                    step = ({1'b0, cur - gap} + ((33'd1 << ewma_shift) - 33'd1)) >> ewma_shift;
                    estimate_us = cur - step[31:0];
                end
                if (report_count != COUNT_MAX) begin
                    report_count++;
                end
                r.status = ST_UPDATE;
            end
        end
        r.estimate = estimate_us;
        if (report_count < min_count || estimate_us == 0) begin
            r.reload = '0;
        end else begin
            counts    = limit_us(estimate_us) * {24'b0, clk_mhz};
            counts_m1 = (counts != 0) ? counts - 32'd1 : 32'd0;
            r.reload  = counts_m1[RELOAD_W-1:0];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report_word want;
        if (!i_rst_n) begin
            last_arrival = '0;
            estimate_us  = 32'd1000;
            report_count = '0;
            clk_mhz      = 8'd24;
            min_count    = 3'd5;
            ewma_shift   = 4'd4;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NOMINAL: begin
                        estimate_us = limit_us({18'b0, i_cfg_wdata});
                    end
                    CFG_CLOCK:   clk_mhz = i_cfg_wdata[CLK_W-1:0];
                    CFG_MIN_REP: min_count = i_cfg_wdata[CNT_W-1:0];
                    CFG_SHIFT:   ewma_shift = i_cfg_wdata[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result word with nothing expected: estimate %0d status %0d",
                           i_m_axis_tdata[31:0], i_m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("interval_estimate_us", want.estimate, i_m_axis_tdata[31:0]);
                    check_field("arrival_status", {30'b0, want.status}, {30'b0, i_m_axis_tuser});
                    check_field("timer_reload", {10'b0, want.reload},
                                {10'b0, i_m_axis_tdata[53:32]});
                    check_field("tdata_pad", 32'd0, {30'b0, i_m_axis_tdata[55:54]});
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_reports.push_back(next_report(i_s_axis_tdata));
            end
        end
        o_pending <= expected_reports.size();
        o_errors  <= mismatch_count;
    end

endmodule

/* sim/report_interval_tracker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// report_interval_tracker_tb: stimulus and verdict for the interval tracker
// Sends directed arrival sequences (wrap, dropout, burst, decay to a zero
// estimate, estimates beyond 2^30) and then phases of random settings with
// mostly periodic arrivals, while both stream sides idle at random and the
// receiver holds off once for a long stretch. A checker module scores it.
// ----------------------------------------------------------------------------

module report_interval_tracker_tb;

    import rit_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int DRAIN_CYCLES   = 8;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata   = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [55:0]           m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr     = CFG_NOMINAL;
    logic [13:0]           i_cfg_wdata    = '0;

    int          pending;
    int          errors;
    int          idle_cycles = 0;
    logic [31:0] now_us      = '0;
    bit          no_gaps     = 1'b0;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;

    report_interval_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    report_interval_tracker_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    always #5 i_clk = ~i_clk;

    // Abort when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    initial begin : receiver
        int run_len;
        int stall_len;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                // hold off long enough for the block to back up into its input
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            run_len   = $urandom_range(1, 24);
            stall_len = pick_idle();
            m_axis_tready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            if (stall_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    task automatic push_arrival(input logic [31:0] ts);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ts;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = pick_idle();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_gap(input logic [31:0] gap);
        now_us = now_us + gap;
        push_arrival(now_us);
    endtask

    // Drop valid, then wait until every word has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [13:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [13:0] nominal, input logic [7:0] clk_mhz,
                                  input logic [2:0] min_rep, input logic [3:0] shift);
        put_reg(CFG_NOMINAL, nominal);
        put_reg(CFG_CLOCK, {6'b0, clk_mhz});
        put_reg(CFG_MIN_REP, {11'b0, min_rep});
        put_reg(CFG_SHIFT, {10'b0, shift});
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        logic [13:0] nominal;
        logic [31:0] period;
        int          kind;
        case ($urandom_range(0, 7))
            0:       nominal = 14'($urandom_range(0, 124));
            1:       nominal = 14'($urandom_range(10001, 16383));
            2:       nominal = LDVAL_US_MIN;
            3:       nominal = LDVAL_US_MAX;
            default: nominal = 14'($urandom_range(125, 10000));
        endcase
        apply_settings(nominal, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                       4'($urandom_range(0, 15)));
        period = (nominal < LDVAL_US_MIN) ? {18'b0, LDVAL_US_MIN} :
                 (nominal > LDVAL_US_MAX) ? {18'b0, LDVAL_US_MAX} : {18'b0, nominal};
        for (int n = 0; n < items; n++) begin
            // let the report rate drift now and then
            if ($urandom_range(0, 49) == 0) begin
                period = $urandom_range(0, 1) ? period + period / 2 : period - period / 3;
                if (period < 8) period = 8;
                if (period > 1000000) period = 1000000;
            end
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                send_gap(period - period / 3 + $urandom_range(0, (2 * period) / 3));
            end else if (kind < 83) begin
                send_gap(5 * period + $urandom_range(0, 20 * period));
            end else if (kind < 91) begin
                send_gap($urandom_range(0, period / 3));
            end else if (kind < 96) begin
                now_us = $urandom;
                push_arrival(now_us);
            end else begin
                send_gap($urandom);
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] gap;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: wrap across zero, reach confidence, dropout edge, burst
        now_us = 32'hFFFF_FC00;
        push_arrival(now_us);
        repeat (4) send_gap(32'd1000);
        send_gap(32'd4001);
        send_gap(32'd4000);
        send_gap(32'd0);
        now_us = '0;
        push_arrival(now_us);
        settle();

        // nominal below range, zero clock, zero minimum, no smoothing:
        // halve the estimate down to zero, then seed it from the next gap
        apply_settings(14'd0, 8'd0, 3'd0, 4'd0);
        send_gap(32'd62);
        send_gap(32'd31);
        send_gap(32'd15);
        send_gap(32'd7);
        send_gap(32'd3);
        send_gap(32'd1);
        send_gap(32'd0);
        send_gap(32'd5);
        settle();

        // nominal above range, top clock and minimum: grow the estimate past 2^30
        apply_settings(14'h3FFF, 8'd255, 3'd7, 4'd0);
        gap = 32'd40000;
        repeat (9) begin
            send_gap(gap);
            gap = gap << 2;
        end
        send_gap(32'hFFFF_FFFF);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_gaps = (p % 4 == 0);
            if (p == 0) hold_req = 1'b1;
            random_phase(PHASE_ITEMS);
            settle();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
